@@ design/ibh_pkg.sv @@
package ibh_pkg;

  localparam int DEF_CAPACITY  = 256;
  localparam int DEF_KEY_WIDTH = 32;
  localparam int ID_COUNT      = 256;
  localparam int ID_W          = 8;
  localparam int CFG_W         = 9;
  localparam logic [CFG_W-1:0] CAP_RESET = 9'd256;

  typedef enum logic [1:0] {
    REQ_INSERT   = 2'd0,
    REQ_POP      = 2'd1,
    REQ_DECREASE = 2'd2,
    REQ_NONE     = 2'd3
  } req_t;

  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_FULL     = 3'd1,
    ST_EMPTY    = 3'd2,
    ST_ABSENT   = 3'd3,
    ST_PRESENT  = 3'd4,
    ST_NOT_LOWER = 3'd5
  } status_t;

endpackage

@@ design/ibh_if.sv @@
interface ibh_req_if;
  logic        valid;
  logic        ready;
  logic [1:0]  req_type;
  logic [7:0]  item_id;
  logic [31:0] priority_req;
  modport source (output valid, req_type, item_id, priority_req, input ready);
  modport sink   (input valid, req_type, item_id, priority_req, output ready);
endinterface

interface ibh_res_if;
  logic        valid;
  logic        ready;
  logic [2:0]  status;
  logic [7:0]  out_id;
  logic [31:0] out_priority;
  logic [7:0]  out_position;
  modport source (output valid, status, out_id, out_priority, out_position, input ready);
  modport sink   (input valid, status, out_id, out_priority, out_position, output ready);
endinterface

interface ibh_cfg_if;
  logic       valid;
  logic       ready;
  logic [8:0] data;
  modport source (output valid, data, input ready);
  modport sink   (input valid, data, output ready);
endinterface

@@ design/ibh_slot_ram.sv @@
module ibh_slot_ram import ibh_pkg::*; #(
  parameter int DEPTH = DEF_CAPACITY,
  parameter int WIDTH = DEF_KEY_WIDTH + ID_W,
  parameter int AW    = $clog2(DEF_CAPACITY)
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic [AW-1:0]    rd_a_addr,
  input  logic [AW-1:0]    rd_b_addr,
  output logic [WIDTH-1:0] rd_a_data,
  output logic [WIDTH-1:0] rd_b_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write one slot, read two slots with registered data
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_a_data <= mem[rd_a_addr];
    rd_b_data <= mem[rd_b_addr];
  end

endmodule

@@ design/indexed_binary_min_heap.sv @@
// Indexed binary min-heap of (key, id) entries with decrease-key.
// Channels: in_ch carries one request (insert, pop minimum, decrease key),
// out_ch returns exactly one result per request (status, id, key, slot),
// cfg_ch writes the capacity limit and is always ready; write it only while
// no request is in flight.
// A request that moves an entry sifts it one heap level per step (at most
// log2(CAPACITY) levels) and then places the moving entry.
// One request is worked at a time; the next is taken once the result sits in
// the output register. The sift loop is bound by the heap slot memory, which
// is read (two ports) and written once per level.
// Reset (rst_n low, synchronous) empties the heap, marks every id absent and
// sets the capacity limit to 256. Slot contents are left as they are.
// When the receiver stalls, the result holds in the output register; a
// following request is accepted and worked, then waits until the held result
// transfers.
module indexed_binary_min_heap import ibh_pkg::*; #(
  parameter int CAPACITY  = DEF_CAPACITY,
  parameter int KEY_WIDTH = DEF_KEY_WIDTH
) (
  input  logic     clk,
  input  logic     rst_n,
  ibh_req_if.sink   in_ch,
  ibh_res_if.source out_ch,
  ibh_cfg_if.sink   cfg_ch
);

  localparam int SW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);
  localparam int EW = KEY_WIDTH + ID_W;
  localparam int XW = KEY_WIDTH + 32;
  localparam int PX = SW + 8;
  localparam int LW = SW + 2;
  localparam int MW = (CW > CFG_W) ? CW : CFG_W;

  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_LOOK  = 7'b0000010,
    S_CHK   = 7'b0000100,
    S_UP    = 7'b0001000,
    S_DOWN  = 7'b0010000,
    S_PLACE = 7'b0100000,
    S_OUT   = 7'b1000000
  } state_t;

  state_t state_r, state_nxt;
  req_t req_r, req_nxt;
  logic [ID_W-1:0] id_r, id_nxt;
  logic [KEY_WIDTH-1:0] key_r, key_nxt;
  logic [KEY_WIDTH-1:0] mov_key_r, mov_key_nxt;
  logic [ID_W-1:0] mov_id_r, mov_id_nxt;
  logic [SW-1:0] pos_r, pos_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic [CFG_W-1:0] cap_r;
  logic present_r;
  logic [ID_COUNT-1:0] id_valid_r, id_valid_nxt;
  status_t res_status_r, res_status_nxt;
  logic [ID_W-1:0] res_id_r, res_id_nxt;
  logic [KEY_WIDTH-1:0] res_key_r, res_key_nxt;
  logic [SW-1:0] res_pos_r, res_pos_nxt;
  logic out_valid_r, out_valid_nxt;
  logic out_load;
  logic [2:0] out_status_r;
  logic [7:0] out_id_r, out_pos_r;
  logic [31:0] out_key_r;

  // slot memory ports
  logic ram_we;
  logic [SW-1:0] ram_wa, rd_a_addr, rd_b_addr;
  logic [EW-1:0] ram_wd, rd_a_data, rd_b_data;

  // id position memory
  logic [SW-1:0] idpos_mem [ID_COUNT];
  logic [SW-1:0] idpos_rd_r;
  logic idpos_we;
  logic [ID_W-1:0] idpos_wa;
  logic [SW-1:0] idpos_wd;

  logic [XW-1:0] prio_ext, res_key_ext;
  logic [PX-1:0] res_pos_ext;
  logic [KEY_WIDTH-1:0] a_key, b_key;
  logic [ID_W-1:0] a_id;
  logic [SW-1:0] par, par2, last_slot;
  logic [LW-1:0] l_w, r_w, cnt_w, pick_w, pl_w, pr_w;
  logic lv, rv, full;

  ibh_slot_ram #(.DEPTH(CAPACITY), .WIDTH(EW), .AW(SW)) u_slot_ram (
    .clk       (clk),
    .wr_en     (ram_we),
    .wr_addr   (ram_wa),
    .wr_data   (ram_wd),
    .rd_a_addr (rd_a_addr),
    .rd_b_addr (rd_b_addr),
    .rd_a_data (rd_a_data),
    .rd_b_data (rd_b_data)
  );

  assign prio_ext    = XW'(in_ch.priority_req);
  assign res_key_ext = XW'(res_key_r);
  assign res_pos_ext = PX'(res_pos_r);
  assign a_key = rd_a_data[KEY_WIDTH-1:0];
  assign b_key = rd_b_data[KEY_WIDTH-1:0];
  assign a_id  = rd_a_data[EW-1 -: ID_W];
  assign par   = SW'((pos_r - SW'(1)) >> 1);
  assign par2  = SW'((par - SW'(1)) >> 1);
  assign last_slot = SW'(count_r - CW'(1));
  assign l_w   = LW'({pos_r, 1'b1});
  assign r_w   = l_w + LW'(1);
  assign cnt_w = LW'(count_r);
  assign lv    = l_w < cnt_w;
  assign rv    = r_w < cnt_w;
  assign full  = (MW'(count_r) >= MW'(cap_r)) || (MW'(count_r) == MW'(CAPACITY));
  assign pl_w  = LW'({pick_w[SW-1:0], 1'b1});
  assign pr_w  = pl_w + LW'(1);

  assign in_ch.ready  = (state_r == S_IDLE);
  assign cfg_ch.ready = 1'b1;
  assign out_ch.valid = out_valid_r;
  assign out_ch.status = out_status_r;
  assign out_ch.out_id = out_id_r;
  assign out_ch.out_priority = out_key_r;
  assign out_ch.out_position = out_pos_r;

  // request sequencer
  always_comb begin
    state_nxt = state_r;
    req_nxt = req_r;
    id_nxt = id_r;
    key_nxt = key_r;
    mov_key_nxt = mov_key_r;
    mov_id_nxt = mov_id_r;
    pos_nxt = pos_r;
    count_nxt = count_r;
    id_valid_nxt = id_valid_r;
    res_status_nxt = res_status_r;
    res_id_nxt = res_id_r;
    res_key_nxt = res_key_r;
    res_pos_nxt = res_pos_r;
    out_valid_nxt = out_valid_r && !out_ch.ready;
    out_load = 1'b0;
    ram_we = 1'b0;
    ram_wa = pos_r;
    ram_wd = {mov_id_r, mov_key_r};
    rd_a_addr = '0;
    rd_b_addr = '0;
    idpos_we = 1'b0;
    idpos_wa = mov_id_r;
    idpos_wd = pos_r;
    pick_w = l_w;
    case (state_r)
      S_IDLE: begin
        rd_a_addr = '0;
        rd_b_addr = last_slot;
        if (in_ch.valid) begin
          req_nxt = req_t'(in_ch.req_type);
          id_nxt = in_ch.item_id;
          key_nxt = prio_ext[KEY_WIDTH-1:0];
          res_status_nxt = ST_OK;
          res_id_nxt = in_ch.item_id;
          res_key_nxt = '0;
          res_pos_nxt = '0;
          state_nxt = S_LOOK;
        end
      end
      S_LOOK: begin
        pos_nxt = idpos_rd_r;
        rd_a_addr = idpos_rd_r;
        case (req_r)
          REQ_INSERT: begin
            if (present_r) begin
              state_nxt = S_CHK;
            end else if (full) begin
              res_status_nxt = ST_FULL;
              res_key_nxt = key_r;
              state_nxt = S_OUT;
            end else begin
              mov_key_nxt = key_r;
              mov_id_nxt = id_r;
              pos_nxt = SW'(count_r);
              count_nxt = count_r + CW'(1);
              id_valid_nxt[id_r] = 1'b1;
              res_key_nxt = key_r;
              if (count_r == '0) begin
                state_nxt = S_PLACE;
              end else begin
                rd_a_addr = SW'((SW'(count_r) - SW'(1)) >> 1);
                state_nxt = S_UP;
              end
            end
          end
          REQ_POP: begin
            if (count_r == '0) begin
              res_status_nxt = ST_EMPTY;
              res_id_nxt = '0;
              state_nxt = S_OUT;
            end else begin
              res_id_nxt = a_id;
              res_key_nxt = a_key;
              id_valid_nxt[a_id] = 1'b0;
              count_nxt = count_r - CW'(1);
              mov_key_nxt = b_key;
              mov_id_nxt = rd_b_data[EW-1 -: ID_W];
              pos_nxt = '0;
              rd_a_addr = SW'(1);
              rd_b_addr = SW'(2);
              state_nxt = (count_r == CW'(1)) ? S_OUT : S_DOWN;
            end
          end
          REQ_DECREASE: begin
            if (!present_r) begin
              res_status_nxt = ST_ABSENT;
              state_nxt = S_OUT;
            end else begin
              state_nxt = S_CHK;
            end
          end
          default: begin
            state_nxt = S_OUT;
          end
        endcase
      end
      S_CHK: begin
        if (req_r == REQ_INSERT) begin
          res_status_nxt = ST_PRESENT;
          res_key_nxt = a_key;
          res_pos_nxt = pos_r;
          state_nxt = S_OUT;
        end else if (key_r > a_key) begin
          res_status_nxt = ST_NOT_LOWER;
          res_key_nxt = a_key;
          res_pos_nxt = pos_r;
          state_nxt = S_OUT;
        end else begin
          mov_key_nxt = key_r;
          mov_id_nxt = id_r;
          res_key_nxt = key_r;
          rd_a_addr = par;
          state_nxt = (pos_r == '0) ? S_PLACE : S_UP;
        end
      end
      S_UP: begin
        // move the parent down into the hole while it is strictly larger
        if (a_key > mov_key_r) begin
          ram_we = 1'b1;
          ram_wd = rd_a_data;
          idpos_we = 1'b1;
          idpos_wa = a_id;
          pos_nxt = par;
          rd_a_addr = par2;
          state_nxt = (par == '0) ? S_PLACE : S_UP;
        end else begin
          state_nxt = S_PLACE;
        end
      end
      S_DOWN: begin
        // pull the smaller child up while it is strictly below the moving key
        if (!lv) begin
          state_nxt = S_PLACE;
        end else if (!rv) begin
          if (a_key < mov_key_r) begin
            ram_we = 1'b1;
            ram_wd = rd_a_data;
            idpos_we = 1'b1;
            idpos_wa = a_id;
            pick_w = l_w;
            pos_nxt = pick_w[SW-1:0];
            rd_a_addr = pl_w[SW-1:0];
            rd_b_addr = pr_w[SW-1:0];
          end else begin
            state_nxt = S_PLACE;
          end
        end else if (a_key >= mov_key_r && b_key >= mov_key_r) begin
          state_nxt = S_PLACE;
        end else begin
          ram_we = 1'b1;
          idpos_we = 1'b1;
          if (a_key > b_key) begin
            pick_w = r_w;
            ram_wd = rd_b_data;
            idpos_wa = rd_b_data[EW-1 -: ID_W];
          end else begin
            pick_w = l_w;
            ram_wd = rd_a_data;
            idpos_wa = a_id;
          end
          pos_nxt = pick_w[SW-1:0];
          rd_a_addr = pl_w[SW-1:0];
          rd_b_addr = pr_w[SW-1:0];
        end
      end
      S_PLACE: begin
        ram_we = 1'b1;
        idpos_we = 1'b1;
        if (req_r != REQ_POP) begin
          res_pos_nxt = pos_r;
        end
        state_nxt = S_OUT;
      end
      S_OUT: begin
        if (!out_valid_r || out_ch.ready) begin
          out_load = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      count_r <= '0;
      id_valid_r <= '0;
      cap_r <= CAP_RESET;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
      id_valid_r <= id_valid_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_ch.valid) begin
        cap_r <= cfg_ch.data;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    req_r <= req_nxt;
    id_r <= id_nxt;
    key_r <= key_nxt;
    mov_key_r <= mov_key_nxt;
    mov_id_r <= mov_id_nxt;
    pos_r <= pos_nxt;
    res_status_r <= res_status_nxt;
    res_id_r <= res_id_nxt;
    res_key_r <= res_key_nxt;
    res_pos_r <= res_pos_nxt;
    present_r <= id_valid_r[in_ch.item_id];
    if (out_load) begin
      out_status_r <= res_status_r;
      out_id_r <= res_id_r;
      out_key_r <= res_key_ext[31:0];
      out_pos_r <= res_pos_ext[7:0];
    end
  end

  // id position memory
  always_ff @(posedge clk) begin
    if (idpos_we) begin
      idpos_mem[idpos_wa] <= idpos_wd;
    end
    idpos_rd_r <= idpos_mem[in_ch.item_id];
  end

endmodule
